// ----- hw/rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Sizes, opcode and status codes, stream layouts, and the
// controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH      = 128;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // field widths on the streams
   localparam int OP_W      = 2;
   localparam int FIELD_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 8;
   localparam int REQ_RAW_W = OP_W + FIELD_W;
   localparam int REQ_W     = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_RAW_W = STATUS_W + 3 * FIELD_W + 1 + COUNT_W;
   localparam int RSP_W     = ((RSP_RAW_W + 7) / 8) * 8;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_item;
      logic execute;
      logic capture;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic needs_read;
      logic out_free;
   } stat_type;

   function automatic idx_type idx_inc(input idx_type i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic idx_type idx_dec(input idx_type i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

// ----- hw/rtl/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl: deque sequencer
// Steps each request through execute, an optional ring read, and the
// hand-off to the response register.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cdq_pkg::stat_type stat,
   output cdq_pkg::cmd_type  cmd
);

   cdq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdq_pkg::S_IDLE: begin
            if (req_tvalid) state_in = cdq_pkg::S_EXEC;
         end
         cdq_pkg::S_EXEC: begin
            state_in = stat.needs_read ? cdq_pkg::S_FETCH : cdq_pkg::S_FINISH;
         end
         cdq_pkg::S_FETCH: begin
            state_in = cdq_pkg::S_FINISH;
         end
         cdq_pkg::S_FINISH: begin
            if (stat.out_free) state_in = cdq_pkg::S_IDLE;
         end
         default: state_in = cdq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == cdq_pkg::S_IDLE);
      cmd.load_item = (state_ff == cdq_pkg::S_IDLE) && req_tvalid;
      cmd.execute   = (state_ff == cdq_pkg::S_EXEC);
      cmd.capture   = (state_ff == cdq_pkg::S_FETCH);
      cmd.load_out  = (state_ff == cdq_pkg::S_FINISH) && stat.out_free;
   end

`ifndef NO_ASSERTIONS
   a_fetch_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdq_pkg::S_FETCH) |-> ($past(state_ff) == cdq_pkg::S_EXEC))
      else $error("fetch not preceded by execute");
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> (state_ff == cdq_pkg::S_EXEC))
      else $error("accepted beat did not enter execute");
   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdq_pkg::S_FINISH && !stat.out_free) |=>
      (state_ff == cdq_pkg::S_FINISH))
      else $error("left finish while response register busy");
`endif

endmodule

// ----- hw/rtl/cdq_dpath.sv -----
// ----------------------------------------------------------------------------
// cdq_dpath: deque datapath
// Ring store, head/tail/count registers, cached front and rear words,
// and the response register.
// ----------------------------------------------------------------------------
module cdq_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [cdq_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cdq_pkg::RSP_W-1:0] rsp_tdata,
   input  cdq_pkg::cmd_type          cmd,
   output cdq_pkg::stat_type         stat
);

   localparam int FW  = cdq_pkg::FIELD_W;
   localparam int DW  = cdq_pkg::DATA_WIDTH;
   localparam int CW  = cdq_pkg::COUNT_W;
   localparam int PAD = cdq_pkg::RSP_W - cdq_pkg::RSP_RAW_W;

   cdq_pkg::data_type   mem [cdq_pkg::DEPTH];

   cdq_pkg::opcode_type op_ff;
   cdq_pkg::data_type   val_ff;
   cdq_pkg::idx_type    head_ff, head_in;
   cdq_pkg::idx_type    tail_ff, tail_in;
   cdq_pkg::cnt_type    count_ff, count_in;
   cdq_pkg::data_type   front_ff, front_in;
   cdq_pkg::data_type   rear_ff, rear_in;
   cdq_pkg::status_type status_ff, status_in;
   cdq_pkg::data_type   popped_ff, popped_in;
   cdq_pkg::data_type   rd_data_ff;
   logic [cdq_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   cdq_pkg::idx_type    wr_addr, rd_addr;
   logic                wr_en;
   logic                is_push;
   logic                is_full;
   logic                is_empty;

   assign is_push  = (op_ff == cdq_pkg::OP_PUSH_FRONT) || (op_ff == cdq_pkg::OP_PUSH_REAR);
   assign is_full  = (count_ff == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;

      if (cmd.execute) begin
         status_in = cdq_pkg::STAT_DONE;
         popped_in = '0;
         if (is_push) begin
            if (is_full) begin
               status_in = cdq_pkg::STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (op_ff == cdq_pkg::OP_PUSH_FRONT) begin
                  head_in  = cdq_pkg::idx_dec(head_ff);
                  wr_addr  = head_in;
                  front_in = val_ff;
                  if (is_empty) rear_in = val_ff;
               end else begin
                  wr_addr = tail_ff;
                  tail_in = cdq_pkg::idx_inc(tail_ff);
                  rear_in = val_ff;
                  if (is_empty) front_in = val_ff;
               end
            end
         end else begin
            if (is_empty) begin
               status_in = cdq_pkg::STAT_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               if (op_ff == cdq_pkg::OP_POP_FRONT) begin
                  popped_in = front_ff;
                  head_in   = cdq_pkg::idx_inc(head_ff);
                  rd_addr   = head_in;
               end else begin
                  popped_in = rear_ff;
                  tail_in   = cdq_pkg::idx_dec(tail_ff);
                  rd_addr   = cdq_pkg::idx_dec(tail_in);
               end
            end
         end
      end

      // new end word arrives from the ring's registered read port in the cycle after execute
      if (cmd.capture) begin
         if (op_ff == cdq_pkg::OP_POP_FRONT) front_in = rd_data_ff;
         else rear_in = rd_data_ff;
      end
   end

   always_comb begin
      stat.needs_read = !is_push && (count_ff > cdq_pkg::CNT_W'(1));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      rsp_data_in = {{PAD{1'b0}},
                     CW'(count_ff),
                     is_empty,
                     is_empty ? {FW{1'b0}} : FW'(rear_ff),
                     is_empty ? {FW{1'b0}} : FW'(front_ff),
                     FW'(popped_ff),
                     status_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= cdq_pkg::opcode_type'(req_tdata[cdq_pkg::OP_W-1:0]);
         val_ff <= DW'(req_tdata[cdq_pkg::OP_W +: FW]);
      end
      front_ff  <= front_in;
      rear_ff   <= rear_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      if (cmd.load_out) rsp_data_ff <= rsp_data_in;
   end

   // ring store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= val_ff;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   logic [cdq_pkg::IDX_W:0] ring_sum;
   cdq_pkg::idx_type        ring_end;
   assign ring_sum = {1'b0, head_ff} + (cdq_pkg::IDX_W + 1)'(count_ff);
   assign ring_end = (ring_sum >= (cdq_pkg::IDX_W + 1)'(cdq_pkg::DEPTH)) ?
      cdq_pkg::IDX_W'(ring_sum - (cdq_pkg::IDX_W + 1)'(cdq_pkg::DEPTH)) :
      cdq_pkg::IDX_W'(ring_sum);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
      else $error("occupancy above depth");
   a_ring_span: assert property (@(posedge clock) disable iff (reset)
      tail_ff == ring_end)
      else $error("tail does not match head plus count");
   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && is_push && is_full) |=>
      (count_ff == cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) && $stable(head_ff) && $stable(tail_ff))
      else $error("refused push changed the ring");
`endif

endmodule

// ----- hw/rtl/circular_deque.sv -----
// Sequence: a push or a refused op steps from execute to finish; a pop that
// leaves entries needs one ring read, through the registered read port, in a
// fetch state between them. Finish waits for the response register to be
// free, and no new request is taken until the sequencer is back in idle.
// Reset: synchronous; deque empty, indices zero, no response pending.
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue over a ring store
// Push/pop at either end with full/empty refusal; each request returns
// status, popped word, front/rear words and occupancy.
// ----------------------------------------------------------------------------
module circular_deque (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // opcode[1:0], push_value[33:2], zero pad
   input  logic [cdq_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status[1:0], popped_value[33:2], front_value[65:34], rear_value[97:66],
   // is_empty[98], entry_count[106:99], zero pad
   output logic [cdq_pkg::RSP_W-1:0] rsp_tdata
);

   cdq_pkg::cmd_type  cmd;
   cdq_pkg::stat_type stat;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cdq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ----- tb/circular_deque_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking bench for the circular deque
// Streams push/pop beats at both ends with random gaps and back-pressure,
// tracks the deque contents in a local ring, and checks every response
// field against the predicted status, popped word, front/rear and count.
// ----------------------------------------------------------------------------
module circular_deque_tb;

   typedef struct packed {
      cdq_pkg::status_type status;
      logic [31:0]         popped;
      logic [31:0]         front;
      logic [31:0]         rear;
      logic                empty;
      logic [7:0]          count;
   } deque_view_type;

   localparam int RANDOM_BEATS  = 650;
   localparam int SEND_IDLE_PCT = 35;
   localparam int RECV_IDLE_PCT = 35;
   localparam int HOLD_CYCLES   = 300;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [cdq_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [cdq_pkg::RSP_W-1:0] rsp_tdata;

   logic [cdq_pkg::REQ_W-1:0] pending_beats[$];
   deque_view_type            expected_views[$];

   // local copy of the deque
   cdq_pkg::data_type ring_copy[cdq_pkg::DEPTH];
   int       head_slot  = 0;
   int       tail_slot  = 0;
   int       fill_level = 0;

   int sent_beats    = 0;
   int done_beats    = 0;
   int total_beats   = 0;
   int errors        = 0;
   int hold_left     = 0;
   bit pressure_done = 1'b0;
   bit req_beat_done = 1'b0;

   circular_deque DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic cdq_pkg::data_type rand_word();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_beat(input cdq_pkg::opcode_type op, input cdq_pkg::data_type value);
      logic [cdq_pkg::REQ_W-1:0] beat;
      beat       = '0;
      beat[1:0]  = op;
      beat[33:2] = value;
      pending_beats.push_back(beat);
   endtask

   // random run with a given bias toward pushes
   task automatic queue_run(input int length, input int push_pct);
      cdq_pkg::opcode_type op;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
         else
            op = $urandom_range(1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
         queue_beat(op, rand_word());
      end
   endtask

   task automatic deque_apply(input logic [cdq_pkg::REQ_W-1:0] beat);
      cdq_pkg::opcode_type op;
      cdq_pkg::data_type   value;
      deque_view_type      view;
      op          = cdq_pkg::opcode_type'(beat[1:0]);
      value       = beat[33:2];
      view        = '0;
      view.status = cdq_pkg::STAT_DONE;
      case (op)
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
            if (fill_level == cdq_pkg::DEPTH) begin
               view.status = cdq_pkg::STAT_FULL;
            end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
               head_slot = (head_slot + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
               ring_copy[head_slot] = value;
               fill_level++;
            end else begin
               ring_copy[tail_slot] = value;
               tail_slot = (tail_slot + 1) % cdq_pkg::DEPTH;
               fill_level++;
            end
         end
         default: begin
            if (fill_level == 0) begin
               view.status = cdq_pkg::STAT_EMPTY;
            end else if (op == cdq_pkg::OP_POP_FRONT) begin
               view.popped = ring_copy[head_slot];
               head_slot = (head_slot + 1) % cdq_pkg::DEPTH;
               fill_level--;
            end else begin
               tail_slot = (tail_slot + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
               view.popped = ring_copy[tail_slot];
               fill_level--;
            end
         end
      endcase
      if (fill_level != 0) begin
         view.front = ring_copy[head_slot];
         view.rear  = ring_copy[(tail_slot + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH];
      end
      view.empty = (fill_level == 0);
      view.count = 8'(fill_level);
      expected_views.push_back(view);
   endtask

   task automatic compare_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
   endtask

   // sender: next beat at the falling edge once the current one is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_beat_done) begin
            if (pending_beats.size() > 0 &&
                ((sent_beats >= 350 && sent_beats < 470) ||
                 $urandom_range(99) >= SEND_IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_beats.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         req_beat_done = 1'b0;
      end
   end

   // receiver: random stalls, one long hold-off to fill the block up
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!pressure_done && done_beats >= 120) begin
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES - 1;
            rsp_tready   <= 1'b0;
         end else begin
            rsp_tready <= (done_beats >= 500 && done_beats < 620) ||
                          $urandom_range(99) >= RECV_IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      deque_view_type want;
      if (!reset) begin
         // responses first: a beat taken on this edge cannot answer yet
         if (rsp_tvalid && rsp_tready) begin
            done_beats++;
            if (expected_views.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_views.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
               compare_field("popped_value", want.popped, rsp_tdata[33:2]);
               compare_field("front_value", want.front, rsp_tdata[65:34]);
               compare_field("rear_value", want.rear, rsp_tdata[97:66]);
               compare_field("is_empty", 32'(want.empty), 32'(rsp_tdata[98]));
               compare_field("entry_count", 32'(want.count), 32'(rsp_tdata[106:99]));
            end
         end
         if (req_tvalid && req_tready) begin
            deque_apply(req_tdata);
            sent_beats++;
            req_beat_done = 1'b1;
         end
      end
   end

   initial begin
      int directed_beats;
      // refusals on empty, wrap of both indices, extreme words
      queue_beat(cdq_pkg::OP_POP_FRONT, 32'h1234_5678);
      queue_beat(cdq_pkg::OP_POP_REAR, 32'hFFFF_FFFF);
      queue_beat(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      queue_beat(cdq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
      queue_beat(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      queue_beat(cdq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
      queue_beat(cdq_pkg::OP_POP_FRONT, 32'h0);
      queue_beat(cdq_pkg::OP_POP_REAR, 32'h0);
      queue_beat(cdq_pkg::OP_POP_FRONT, 32'h0);
      queue_beat(cdq_pkg::OP_POP_REAR, 32'h0);
      queue_beat(cdq_pkg::OP_POP_REAR, 32'h0);
      queue_beat(cdq_pkg::OP_PUSH_REAR, 32'h5555_5555);
      queue_beat(cdq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
      queue_beat(cdq_pkg::OP_POP_REAR, 32'hAAAA_AAAA);
      queue_beat(cdq_pkg::OP_POP_REAR, 32'h5555_5555);
      queue_beat(cdq_pkg::OP_POP_FRONT, 32'h0);
      directed_beats = pending_beats.size();

      // fill past full, drain past empty, then mixed runs
      queue_run(190, 92);
      queue_run(190, 8);
      while (pending_beats.size() - directed_beats < RANDOM_BEATS) begin
         case ($urandom_range(2))
            0: queue_run($urandom_range(20, 80), 50);
            1: queue_run($urandom_range(20, 80), 80);
            default: queue_run($urandom_range(20, 80), 20);
         endcase
      end
      total_beats = pending_beats.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (sent_beats == total_beats);
      wait (expected_views.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_views.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
